>>> rtl/core/acf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Comb filter package
// Shared sizes, register indexes and the structs that pass between the
// front end, the descriptor queue and the back end of the comb filter.
// ----------------------------------------------------------------------------
package acf_pkg;

	localparam int MAX_DELAY    = 4096;
	localparam int MAX_CHANNELS = 2;

	// Field widths fixed by the interface.
	localparam int CH_W     = 1;
	localparam int SAMPLE_W = 16;
	localparam int GAIN_W   = 16;
	localparam int DLY_W    = 13;

	localparam int POS_W    = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
	localparam int DIST_W   = $clog2(MAX_DELAY + 1);
	localparam int CH_IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int STORE_DEPTH = MAX_CHANNELS * MAX_DELAY;
	localparam int ADDR_W   = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

	localparam int QUEUE_DEPTH = 4;
	localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Configuration port.
	localparam int PADDR_W   = 4;
	localparam int PDATA_W   = 32;
	localparam int REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_FILTER_MODE  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_GAIN         = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_DELAY_LENGTH = 2'd2;

	typedef struct packed {
		logic                filter_mode;
		logic [GAIN_W-1:0]   gain;
		logic [DLY_W-1:0]    delay_length;
	} cfg_t;

	// One classified sample on its way to the back end.
	typedef struct packed {
		logic                ch_ok;
		logic                rd_ok;
		logic [ADDR_W-1:0]   rd_addr;
		logic [ADDR_W-1:0]   wr_addr;
		logic [SAMPLE_W-1:0] sample;
		logic                last;
	} desc_t;

endpackage
`default_nettype wire

>>> rtl/core/acf_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data. A read at the
// address being written returns the old contents.
// ----------------------------------------------------------------------------
module acf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

>>> rtl/core/acf_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Comb filter front end
// Accepts samples, keeps the per-channel write positions and turns each
// sample into a descriptor with its delay-store read and write addresses.
// ----------------------------------------------------------------------------
module acf_front (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           sample_valid,
	output logic                                sample_stall,
	input  wire logic [acf_pkg::CH_W-1:0]       channel,
	input  wire logic [acf_pkg::SAMPLE_W-1:0]   sample,
	input  wire logic                           last_of_block,
	input  wire acf_pkg::cfg_t                  cfg,
	input  wire logic                           q_full,
	output logic                                push,
	output acf_pkg::desc_t                      push_desc
);

	logic [acf_pkg::POS_W-1:0]    wp_q      [acf_pkg::MAX_CHANNELS];
	logic                         wrapped_q [acf_pkg::MAX_CHANNELS];
	logic [acf_pkg::CH_IDX_W-1:0] idx;
	logic                         ch_ok;
	logic [acf_pkg::POS_W-1:0]    wp_cur;
	logic [acf_pkg::POS_W-1:0]    wp_next;
	logic                         wp_wrap;
	logic [acf_pkg::DIST_W-1:0]   dly_span;
	logic [acf_pkg::POS_W-1:0]    rp;

	assign sample_stall = q_full;
	assign push         = sample_valid && !q_full;

	assign idx     = acf_pkg::CH_IDX_W'(channel);
	assign ch_ok   = 32'(channel) < acf_pkg::MAX_CHANNELS;
	assign wp_cur  = wp_q[idx];
	assign wp_wrap = (32'(wp_cur) + 1) == acf_pkg::MAX_DELAY;
	assign wp_next = wp_wrap ? '0 : wp_cur + 1'b1;

	// A zero delay acts as one; a delay beyond the store acts as the full store.
	always_comb begin
		if (cfg.delay_length == '0) begin
			dly_span = acf_pkg::DIST_W'(1);
		end else if (32'(cfg.delay_length) > acf_pkg::MAX_DELAY) begin
			dly_span = acf_pkg::DIST_W'(acf_pkg::MAX_DELAY);
		end else begin
			dly_span = acf_pkg::DIST_W'(cfg.delay_length);
		end
	end

	always_comb begin
		if (acf_pkg::DIST_W'(wp_cur) >= dly_span) begin
			rp = acf_pkg::POS_W'(acf_pkg::DIST_W'(wp_cur) - dly_span);
		end else begin
			rp = acf_pkg::POS_W'((acf_pkg::DIST_W + 1)'(wp_cur)
				+ (acf_pkg::DIST_W + 1)'(acf_pkg::MAX_DELAY)
				- (acf_pkg::DIST_W + 1)'(dly_span));
		end
	end

	// Positions below the write pointer, or all of them once the channel has
	// wrapped, have been written; anything else still reads as zero.
	always_comb begin
		push_desc.ch_ok   = ch_ok;
		push_desc.rd_ok   = wrapped_q[idx] || (rp < wp_cur);
		push_desc.rd_addr = acf_pkg::ADDR_W'(idx) * acf_pkg::ADDR_W'(acf_pkg::MAX_DELAY)
			+ acf_pkg::ADDR_W'(rp);
		push_desc.wr_addr = acf_pkg::ADDR_W'(idx) * acf_pkg::ADDR_W'(acf_pkg::MAX_DELAY)
			+ acf_pkg::ADDR_W'(wp_cur);
		push_desc.sample  = sample;
		push_desc.last    = last_of_block;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < acf_pkg::MAX_CHANNELS; i++) begin
				wp_q[i]      <= '0;
				wrapped_q[i] <= 1'b0;
			end
		end else if (push && ch_ok) begin
			wp_q[idx] <= wp_next;
			if (wp_wrap) begin
				wrapped_q[idx] <= 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_wp_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(push && ch_ok) |-> (32'(wp_cur) < acf_pkg::MAX_DELAY))
		else $error("write position beyond the delay store");
`endif

endmodule
`default_nettype wire

>>> rtl/core/acf_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Comb filter descriptor queue
// Small FIFO between the front end and the back end so that each side can
// stall on its own.
// ----------------------------------------------------------------------------
module acf_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire acf_pkg::desc_t push_desc,
	output logic                full,
	input  wire logic           pop,
	output logic                empty,
	output acf_pkg::desc_t      head_desc
);

	acf_pkg::desc_t              mem_q [acf_pkg::QUEUE_DEPTH];
	logic [acf_pkg::QIDX_W-1:0]  wr_ptr_q;
	logic [acf_pkg::QIDX_W-1:0]  rd_ptr_q;
	logic [acf_pkg::QCNT_W-1:0]  cnt_q;

	assign full      = 32'(cnt_q) == acf_pkg::QUEUE_DEPTH;
	assign empty     = cnt_q == '0;
	assign head_desc = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (32'(wr_ptr_q) == acf_pkg::QUEUE_DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (32'(rd_ptr_q) == acf_pkg::QUEUE_DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) <= acf_pkg::QUEUE_DEPTH)
		else $error("queue count above its depth");

	a_push_only: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
		else $error("queue count did not follow a push");
`endif

endmodule
`default_nettype wire

>>> rtl/core/acf_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Comb filter back end
// Reads the delayed value from the delay store, forms x + g*d with rounding
// and saturation, writes the store and holds the result for the consumer.
// ----------------------------------------------------------------------------
module acf_back (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire acf_pkg::cfg_t                cfg,
	input  wire logic                         q_empty,
	input  wire acf_pkg::desc_t               head_desc,
	output logic                              pop,
	output logic                              result_valid,
	input  wire logic                         result_stall,
	output logic [acf_pkg::SAMPLE_W-1:0]      filtered_sample,
	output logic                              last_of_block_out
);

	acf_pkg::desc_t                desc_s2;
	logic                          valid_s2;
	logic                          adv_s2;
	logic [acf_pkg::SAMPLE_W-1:0]  rdata;
	logic                          fwd_valid_q;
	logic [acf_pkg::ADDR_W-1:0]    fwd_addr_q;
	logic [acf_pkg::SAMPLE_W-1:0]  fwd_data_q;
	logic [acf_pkg::SAMPLE_W-1:0]  delayed;
	logic signed [31:0]            prod;
	logic signed [31:0]            prod_bias;
	logic signed [16:0]            prod_rnd;
	logic signed [17:0]            sum;
	logic [acf_pkg::SAMPLE_W-1:0]  sum_sat;
	logic [acf_pkg::SAMPLE_W-1:0]  y;
	logic [acf_pkg::SAMPLE_W-1:0]  store_val;
	logic                          out_valid_q;
	logic [acf_pkg::SAMPLE_W-1:0]  out_sample_q;
	logic                          out_last_q;

	assign adv_s2 = valid_s2 && (!out_valid_q || !result_stall);
	assign pop    = !q_empty && (!valid_s2 || adv_s2);

	acf_ram #(
		.WIDTH(acf_pkg::SAMPLE_W),
		.DEPTH(acf_pkg::STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (adv_s2 && desc_s2.ch_ok),
		.waddr(desc_s2.wr_addr),
		.wdata(store_val),
		.re   (pop),
		.raddr(head_desc.rd_addr),
		.rdata(rdata)
	);

	// The write made on the edge that loaded this stage is not yet in the read
	// data, so it is taken from the bypass register instead.
	always_comb begin
		if (!desc_s2.rd_ok) begin
			delayed = '0;
		end else if (fwd_valid_q && (fwd_addr_q == desc_s2.rd_addr)) begin
			delayed = fwd_data_q;
		end else begin
			delayed = rdata;
		end
	end

	assign prod      = 32'($signed(cfg.gain)) * 32'($signed(delayed));
	assign prod_bias = prod + 32'sd16384;
	assign prod_rnd  = prod_bias[31:15];
	assign sum       = {{2{desc_s2.sample[15]}}, desc_s2.sample} + {prod_rnd[16], prod_rnd};

	always_comb begin
		if (sum[17:15] == 3'b000 || sum[17:15] == 3'b111) begin
			sum_sat = sum[15:0];
		end else if (sum[17]) begin
			sum_sat = 16'h8000;
		end else begin
			sum_sat = 16'h7FFF;
		end
	end

	assign y         = desc_s2.ch_ok ? sum_sat : desc_s2.sample;
	assign store_val = cfg.filter_mode ? y : desc_s2.sample;

	always_ff @(posedge clk) begin
		if (pop) begin
			desc_s2 <= head_desc;
		end
		if (adv_s2) begin
			out_sample_q <= y;
			out_last_q   <= desc_s2.last;
		end
		if (adv_s2 && desc_s2.ch_ok) begin
			fwd_addr_q <= desc_s2.wr_addr;
			fwd_data_q <= store_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
			fwd_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				valid_s2 <= 1'b1;
			end else if (adv_s2) begin
				valid_s2 <= 1'b0;
			end
			if (adv_s2) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
			if (adv_s2 && desc_s2.ch_ok) begin
				fwd_valid_q <= 1'b1;
			end
		end
	end

	assign result_valid      = out_valid_q;
	assign filtered_sample   = out_sample_q;
	assign last_of_block_out = out_last_q;

`ifndef SYNTHESIS
	a_adv_lands: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s2 |=> result_valid)
		else $error("finished transaction did not reach the output register");

	a_pop_fills: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> valid_s2)
		else $error("popped descriptor did not reach the compute stage");
`endif

endmodule
`default_nettype wire

>>> rtl/core/audio_comb_filter.sv
`timescale 1ns / 1ps
`default_nettype none
// A sample passes the descriptor queue, compute stage and output register.
// Throughput: one sample per cycle while result_stall is low; the feedback
// path via store read, 16x16 multiply, rounding and saturation closes in stage s2.
// Reset: registers return to mode 0, gain 0, delay 1; per-channel write pointers
// and wrap flags make unwritten store words read as zero; no clearing pass runs.
// ----------------------------------------------------------------------------
// Audio comb filter
// Multichannel feedforward / feedback comb filter on Q1.15 samples with a
// register port for mode, gain and delay.
// ----------------------------------------------------------------------------
module audio_comb_filter (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [acf_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [acf_pkg::PDATA_W-1:0]  pwdata,
	output logic      [acf_pkg::PDATA_W-1:0]  prdata,
	output logic                              pready,
	input  wire logic                         sample_valid,
	output logic                              sample_stall,
	input  wire logic [acf_pkg::CH_W-1:0]     channel,
	input  wire logic [acf_pkg::SAMPLE_W-1:0] sample,
	input  wire logic                         last_of_block,
	output logic                              result_valid,
	input  wire logic                         result_stall,
	output logic [acf_pkg::SAMPLE_W-1:0]      filtered_sample,
	output logic                              last_of_block_out
);

	acf_pkg::cfg_t                  cfg_q;
	logic [acf_pkg::REG_IDX_W-1:0]  reg_idx;
	logic                           cfg_write;
	logic                           push;
	acf_pkg::desc_t                 push_desc;
	logic                           q_full;
	logic                           q_empty;
	logic                           pop;
	acf_pkg::desc_t                 head_desc;

	assign pready    = 1'b1;
	assign reg_idx   = paddr[acf_pkg::PADDR_W-1:2];
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.filter_mode  <= 1'b0;
			cfg_q.gain         <= '0;
			cfg_q.delay_length <= acf_pkg::DLY_W'(1);
		end else if (cfg_write) begin
			unique case (reg_idx)
				acf_pkg::REG_FILTER_MODE:  cfg_q.filter_mode  <= pwdata[0];
				acf_pkg::REG_GAIN:         cfg_q.gain         <= pwdata[acf_pkg::GAIN_W-1:0];
				acf_pkg::REG_DELAY_LENGTH: cfg_q.delay_length <= pwdata[acf_pkg::DLY_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			acf_pkg::REG_FILTER_MODE:  prdata = acf_pkg::PDATA_W'(cfg_q.filter_mode);
			acf_pkg::REG_GAIN:         prdata = acf_pkg::PDATA_W'(cfg_q.gain);
			acf_pkg::REG_DELAY_LENGTH: prdata = acf_pkg::PDATA_W'(cfg_q.delay_length);
			default:                   prdata = '0;
		endcase
	end

	acf_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.channel      (channel),
		.sample       (sample),
		.last_of_block(last_of_block),
		.cfg          (cfg_q),
		.q_full       (q_full),
		.push         (push),
		.push_desc    (push_desc)
	);

	acf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_desc(push_desc),
		.full     (q_full),
		.pop      (pop),
		.empty    (q_empty),
		.head_desc(head_desc)
	);

	acf_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg_q),
		.q_empty          (q_empty),
		.head_desc        (head_desc),
		.pop              (pop),
		.result_valid     (result_valid),
		.result_stall     (result_stall),
		.filtered_sample  (filtered_sample),
		.last_of_block_out(last_of_block_out)
	);

endmodule
`default_nettype wire
